// ===== hdl/tlw_pkg.sv =====
// Package for the tab-expanding line renderer: codes, state and result types,
// and small helpers shared by the step logic, the channel interfaces and the top level.
// No dependencies.
package tlw_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned ColW     = 8;
  localparam int unsigned RowW     = 8;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned TabW     = 5;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CodeW-1:0] CharTab        = 8'h09;
  localparam logic [CodeW-1:0] CharSpace      = 8'h20;
  localparam logic [CodeW-1:0] CharFill       = 8'h00;
  localparam logic [CodeW-1:0] CharPrintFirst = 8'h20;
  localparam logic [CodeW-1:0] CharPrintLast  = 8'h7E;

  localparam logic [TabW-1:0] TabWidthMax   = 5'd16;
  localparam logic [TabW-1:0] TabWidthMin   = 5'd1;
  localparam logic [TabW-1:0] TabWidthReset = 5'd8;
  localparam logic [ColW-1:0] MaxColsMin    = 8'd1;
  localparam logic [ColW-1:0] MaxColsReset  = 8'd80;
  localparam logic [RowW-1:0] RowLast       = 8'd255;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOL  = 1'b1
  } op_e;

  typedef enum logic {
    CFG_TAB_STOP  = 1'b0,
    CFG_ROW_CELLS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ColW-1:0]   column;
    logic [PhaseW-1:0] tab_phase;
    logic [RowW-1:0]   row;
  } state_t;

  typedef struct packed {
    logic [TabW-1:0] tab_stop;
    logic [ColW-1:0] row_cells;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [CodeW-1:0] ch;
    logic             first;
    logic [RowW-1:0]  start_row;
  } item_t;

  typedef struct packed {
    logic [RowW-1:0]  run_row;
    logic [ColW-1:0]  run_column;
    logic [ColW-1:0]  run_length;
    logic [CodeW-1:0] code;
    logic [RowW-1:0]  next_row;
    logic [ColW-1:0]  column_after;
  } result_t;

  // Next row, held at the last row.
  function automatic logic [RowW-1:0] row_inc(input logic [RowW-1:0] r);
    row_inc = (r == RowLast) ? RowLast : r + 1'b1;
  endfunction

endpackage

// ===== hdl/tlw_in_if.sv =====
// Input channel of the line renderer: valid/ready handshake and one character item.
// Depends on tlw_pkg.
interface tlw_in_if;
  import tlw_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [CodeW-1:0] ch;
  logic             first;
  logic [RowW-1:0]  start_row;

  modport source (output valid, operation, ch, first, start_row, input ready);
  modport sink   (input valid, operation, ch, first, start_row, output ready);
endinterface

// ===== hdl/tlw_out_if.sv =====
// Output channel of the line renderer: valid/ready handshake and one run write.
// Depends on tlw_pkg.
interface tlw_out_if;
  import tlw_pkg::*;

  logic             valid;
  logic             ready;
  logic [RowW-1:0]  run_row;
  logic [ColW-1:0]  run_column;
  logic [ColW-1:0]  run_length;
  logic [CodeW-1:0] code;
  logic [RowW-1:0]  next_row;
  logic [ColW-1:0]  column_after;

  modport source (output valid, run_row, run_column, run_length, code, next_row,
                  column_after, input ready);
  modport sink   (input valid, run_row, run_column, run_length, code, next_row,
                  column_after, output ready);
endinterface

// ===== hdl/tlw_step.sv =====
// Combinational step of the line renderer: from the held cursor state, the
// registers and one word, works out the run write and the next cursor state.
// Depends on tlw_pkg.
module tlw_step (
  input  tlw_pkg::state_t  state_i,
  input  tlw_pkg::cfg_t    cfg_i,
  input  tlw_pkg::item_t   item_i,
  output tlw_pkg::state_t  state_o,
  output tlw_pkg::result_t result_o,
  output logic             has_result_o
);
  import tlw_pkg::*;

  logic [TabW-1:0]   tw;
  logic [ColW-1:0]   mc;
  logic [ColW-1:0]   col0, col1;
  logic [RowW-1:0]   row0, row1;
  logic [PhaseW-1:0] ph0;
  logic [TabW-1:0]   phase1;
  logic [TabW-1:0]   phase_sum;
  logic [TabW-1:0]   step;
  logic [ColW:0]     end_col;
  logic              is_tab, is_print, is_eol;
  logic [CodeW-1:0]  code;

  always_comb begin
    // clamp the registers to their working ranges
    if (cfg_i.tab_stop == '0) begin
      tw = TabWidthMin;
    end else if (cfg_i.tab_stop > TabWidthMax) begin
      tw = TabWidthMax;
    end else begin
      tw = cfg_i.tab_stop;
    end
    mc = (cfg_i.row_cells == '0) ? MaxColsMin : cfg_i.row_cells;

    // first word of a line restarts the cursor
    if (item_i.first) begin
      col0 = '0;
      ph0  = '0;
      row0 = item_i.start_row;
    end else begin
      col0 = state_i.column;
      ph0  = state_i.tab_phase;
      row0 = state_i.row;
    end

    is_eol   = (op_e'(item_i.operation) == OP_EOL);
    is_tab   = !is_eol && (item_i.ch == CharTab);
    is_print = !is_eol && (item_i.ch >= CharPrintFirst) && (item_i.ch <= CharPrintLast);
    has_result_o = is_eol || is_tab || is_print;

    phase1 = ({1'b0, ph0} >= tw) ? '0 : {1'b0, ph0};

    if (is_tab) begin
      step = tw - phase1;
      code = CharSpace;
    end else if (is_print) begin
      step = TabW'(1);
      code = item_i.ch;
    end else begin
      step = '0;
      code = CharFill;
    end

    // column left past a narrowed row: wrap before the run
    if (col0 >= mc) begin
      col1   = '0;
      phase1 = '0;
      row1   = row_inc(row0);
    end else begin
      col1 = col0;
      row1 = row0;
    end

    end_col   = {1'b0, col1} + {{(ColW+1-TabW){1'b0}}, step};
    phase_sum = phase1 + step;

    result_o.run_row    = row1;
    result_o.run_column = col1;
    result_o.code       = code;

    if (is_eol) begin
      result_o.run_length = mc - col1;
      state_o.column      = '0;
      state_o.tab_phase   = '0;
      state_o.row         = row_inc(row1);
    end else begin
      result_o.run_length = (end_col > {1'b0, mc}) ? (mc - col1)
                                                   : {{(ColW-TabW){1'b0}}, step};
      if (end_col >= {1'b0, mc}) begin
        // reached the right edge: drop any tab overshoot and wrap
        state_o.column    = '0;
        state_o.tab_phase = '0;
        state_o.row       = row_inc(row1);
      end else begin
        state_o.column    = end_col[ColW-1:0];
        state_o.tab_phase = (phase_sum >= tw) ? '0 : phase_sum[PhaseW-1:0];
        state_o.row       = row1;
      end
    end

    result_o.next_row     = state_o.row;
    result_o.column_after = state_o.column;

    // ignored byte: keep only the line restart
    if (!has_result_o) begin
      state_o.column    = col0;
      state_o.tab_phase = ph0;
      state_o.row       = row0;
    end
  end

endmodule

// ===== hdl/text_line_tab_wrap_renderer_unit.sv =====
// Top level of the tab-expanding line renderer: registers, cursor state,
// result register and handshakes. Depends on tlw_pkg, tlw_in_if, tlw_out_if, tlw_step.
//
//  channel   dir  handshake          word
//  in_i      in   valid/ready        operation, ch, first, start_row
//  out_o     out  valid/ready        run_row, run_column, run_length, code,
//                                    next_row, column_after
//  cfg       in   cfg_we_i (no wait) cfg_index_i, cfg_data_i
//
// One word is taken every cycle unless held off (below); a word that gives a run
// is loaded into the result register at the edge that takes it. The cursor (column,
// tab phase, row) is updated at that same edge, so the next word follows straight on.
// A stalled result holds the input off only while the result register is full
// and out_o.ready is low. Reset clears the cursor and sets tab width 8, 80 columns.
module text_line_tab_wrap_renderer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [tlw_pkg::CfgDataW-1:0] cfg_data_i,
  tlw_in_if.sink                     in_i,
  tlw_out_if.source                  out_o
);
  import tlw_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item;
  result_t result, result_q;
  logic    has_result;
  logic    out_valid_q, out_valid_d;
  logic    accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tab_stop  <= TabWidthReset;
      cfg_q.row_cells <= MaxColsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TAB_STOP:  cfg_q.tab_stop  <= cfg_data_i[TabW-1:0];
        CFG_ROW_CELLS: cfg_q.row_cells <= cfg_data_i[ColW-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  assign item.operation = in_i.operation;
  assign item.ch        = in_i.ch;
  assign item.first     = in_i.first;
  assign item.start_row = in_i.start_row;

  tlw_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .state_o      (state_d),
    .result_o     (result),
    .has_result_o (has_result)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (accept && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  // payload: load only when a run is taken
  always_ff @(posedge clk_i) begin
    if (accept && has_result) begin
      result_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.run_row      = result_q.run_row;
  assign out_o.run_column   = result_q.run_column;
  assign out_o.run_length   = result_q.run_length;
  assign out_o.code         = result_q.code;
  assign out_o.next_row     = result_q.next_row;
  assign out_o.column_after = result_q.column_after;

endmodule
